// File: sv/btod_pkg.sv
// package for the bcd time-of-day clock: transaction types, csr indexes,
// state record and the bcd counting functions
// no dependencies
package btod_pkg;

   // command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // csr indexes
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIFTY_HZ      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALARM_TENTHS  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALARM_SECONDS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALARM_MINUTES = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALARM_HOURS   = 3'd4;

   // prescaler compare values and wrap limit
   localparam logic [2:0] PRESCALE_CMP_50HZ = 3'd4;
   localparam logic [2:0] PRESCALE_CMP_60HZ = 3'd5;
   localparam logic [2:0] PRESCALE_MAX      = 3'd5;

   // bcd limits
   localparam logic [3:0] DIGIT_WRAP   = 4'd10;
   localparam logic [2:0] TENS_SIXTY   = 3'd6;
   localparam logic [4:0] HOURS_TWELVE = 5'h12;
   localparam logic [4:0] HOURS_THIRTEEN = 5'h13;
   localparam logic [7:0] HOURS_RESET  = 8'h01;

   typedef struct packed {
      logic       command;
      logic [3:0] new_tenths;
      logic [6:0] new_seconds;
      logic [6:0] new_minutes;
      logic [7:0] new_hours;
      logic       new_running;
   } req_type;

   typedef struct packed {
      logic [3:0] tenths;
      logic [6:0] seconds;
      logic [6:0] minutes;
      logic [7:0] hours;
      logic       alarm_hit;
      logic       running;
   } rsp_type;

   typedef struct packed {
      logic       fifty_hz_select;
      logic [3:0] alarm_tenths;
      logic [6:0] alarm_seconds;
      logic [6:0] alarm_minutes;
      logic [7:0] alarm_hours;
   } cfg_type;

   typedef struct packed {
      logic [2:0] prescale;
      logic [3:0] tenths;
      logic [6:0] seconds;
      logic [6:0] minutes;
      logic [7:0] hours;
      logic       halted;
   } tod_state_type;

   // advance a two-digit field that wraps at 60; msb of result is the wrap
   function automatic logic [7:0] count_sixty(input logic [6:0] field);
      logic [3:0] lo;
      logic [2:0] hi;
      lo = field[3:0] + 4'd1;
      hi = field[6:4];
      if (lo == DIGIT_WRAP) begin
         lo = 4'd0;
         hi = hi + 3'd1;
      end
      if (hi == TENS_SIXTY) begin
         count_sixty = {1'b1, 7'd0};
      end else begin
         count_sixty = {1'b0, hi, lo};
      end
   endfunction

   // advance hours 12, 1..11 with the pm flag flipping on 11 to 12
   function automatic logic [7:0] count_hours(input logic [7:0] hours);
      logic [3:0] lo;
      logic       hi;
      logic [7:0] hr;
      lo = hours[3:0] + 4'd1;
      hi = hours[4];
      if ({hi, lo} == {1'b0, DIGIT_WRAP}) begin
         lo = 4'd0;
         hi = ~hi;
      end
      hr = {hours[7], 2'b00, hi, lo};
      if (hr[4:0] == HOURS_THIRTEEN) begin
         hr = {hours[7], 7'd1};
      end else if (hr[4:0] == HOURS_TWELVE) begin
         hr[7] = ~hr[7];
      end
      count_hours = hr;
   endfunction

endpackage

// File: sv/btod_csr.sv
// configuration registers of the bcd time-of-day clock
// depends on btod_pkg
module btod_csr
   import btod_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FIFTY_HZ:      cfg_in.fifty_hz_select = csr_wdata[0];
            CSR_ALARM_TENTHS:  cfg_in.alarm_tenths    = csr_wdata[3:0];
            CSR_ALARM_SECONDS: cfg_in.alarm_seconds   = csr_wdata[6:0];
            CSR_ALARM_MINUTES: cfg_in.alarm_minutes   = csr_wdata[6:0];
            CSR_ALARM_HOURS:   cfg_in.alarm_hours     = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/btod_step.sv
// next-state and result logic for one transaction of the time-of-day clock
// depends on btod_pkg
module btod_step
   import btod_pkg::*;
(
   input  req_type       req,
   input  tod_state_type cur,
   input  cfg_type       cfg,
   output tod_state_type nxt,
   output rsp_type       rsp
);

   logic [2:0] cmp;
   logic [2:0] pre_inc;
   logic [3:0] ten_inc;
   logic [7:0] sec_cnt;
   logic [7:0] min_cnt;
   logic       hit;

   assign cmp     = cfg.fifty_hz_select ? PRESCALE_CMP_50HZ : PRESCALE_CMP_60HZ;
   assign pre_inc = cur.prescale + 3'd1;
   assign ten_inc = cur.tenths + 4'd1;
   assign sec_cnt = count_sixty(cur.seconds);
   assign min_cnt = count_sixty(cur.minutes);

   always_comb begin
      nxt = cur;
      hit = 1'b0;
      if (req.command == CMD_LOAD) begin
         nxt.tenths  = req.new_tenths;
         nxt.seconds = req.new_seconds;
         nxt.minutes = req.new_minutes;
         nxt.hours   = req.new_hours;
         nxt.halted  = ~req.new_running;
      end else if (!cur.halted) begin
         if (cur.prescale != cmp) begin
            nxt.prescale = (pre_inc > PRESCALE_MAX) ? 3'd0 : pre_inc;
         end else begin
            nxt.prescale = 3'd0;
            nxt.tenths   = ten_inc;
            if (ten_inc == DIGIT_WRAP) begin
               // tenths roll over, ripple into seconds, minutes, hours
               nxt.tenths  = 4'd0;
               nxt.seconds = sec_cnt[6:0];
               if (sec_cnt[7]) begin
                  nxt.minutes = min_cnt[6:0];
                  if (min_cnt[7]) begin
                     nxt.hours = count_hours(cur.hours);
                  end
               end
            end
            hit = (nxt.tenths == cfg.alarm_tenths) && (nxt.seconds == cfg.alarm_seconds) &&
                  (nxt.minutes == cfg.alarm_minutes) && (nxt.hours == cfg.alarm_hours);
         end
      end
   end

   always_comb begin
      rsp.tenths    = nxt.tenths;
      rsp.seconds   = nxt.seconds;
      rsp.minutes   = nxt.minutes;
      rsp.hours     = nxt.hours;
      rsp.alarm_hit = hit;
      rsp.running   = ~nxt.halted;
   end

endmodule

// File: sv/bcd_time_of_day_clock.sv
// top level of the bcd time-of-day clock: request register, clock state,
// result register and assertions
// depends on btod_pkg, btod_csr, btod_step
//
// A 12-hour BCD time-of-day clock with an AM/PM bit (hours bit 7) and an
// alarm compare. Each request transaction is either a power-line tick or a
// load of the time and run flag; every request gives exactly one response
// transaction carrying the time after it, the run flag and an alarm hit flag.
// Ticks advance a prescaler (divide by five when fifty_hz_select is set,
// six otherwise); each prescaler rollover counts tenths, seconds, minutes and
// hours, and the alarm hit flag is raised when that count lands on the alarm
// time. A halted clock ignores ticks; after reset the clock reads 1 AM and is
// halted. Timing: a request is captured in an input register; whenever the
// result register can advance, the next time and the response are computed
// and written to the clock state and the result register together, so
// rsp_valid rises once the transaction has passed both registers. One
// transaction is taken every cycle while rsp_ready stays high. Configuration
// writes on the csr port take effect at the next edge; the user must make them
// only while no transaction is in flight, as the block does not enforce it.
module bcd_time_of_day_clock
   import btod_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg;

   // input register stage
   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff, in_data_in;

   // clock state
   tod_state_type state_ff, state_in;
   tod_state_type state_nxt;

   // result register stage
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff, out_data_in;
   rsp_type       step_rsp;

   logic          advance;
   logic          req_fire;

   btod_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   btod_step u_step (
      .req (in_data_ff),
      .cur (state_ff),
      .cfg (cfg),
      .nxt (state_nxt),
      .rsp (step_rsp)
   );

   // the result register can take a new value when empty or being drained
   assign advance   = !out_valid_ff || rsp_ready;
   // the input register frees up whenever its transaction moves on
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            // clock state and result commit together
            state_in    = state_nxt;
            out_data_in = step_rsp;
         end
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         state_ff.prescale <= 3'd0;
         state_ff.tenths  <= 4'd0;
         state_ff.seconds <= 7'd0;
         state_ff.minutes <= 7'd0;
         state_ff.hours   <= HOURS_RESET;
         state_ff.halted  <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef ASSERT_OFF
   // prescaler never leaves its 0..5 range
   a_prescale_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.prescale <= PRESCALE_MAX)
      else $error("prescaler out of range");

   // an alarm hit only comes from a count, so the clock must be running
   a_hit_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alarm_hit |-> rsp_data.running)
      else $error("alarm hit on halted clock");

   // a captured transaction is held while the result stage is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a transaction");

   // a tick on a halted clock leaves the time untouched
   a_halt_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && in_data_ff.command == CMD_TICK && state_ff.halted
      |=> $stable(state_ff))
      else $error("halted clock changed on a tick");
`endif

endmodule
